>>> rtl/core/uart_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// uart frame receiver assertion macros
// shared concurrent assertion forms for the receiver checkers
// ----------------------------------------------------------------------------
`ifndef UART_FRAME_RECEIVER_ASSERT_SVH
`define UART_FRAME_RECEIVER_ASSERT_SVH

// implication checked at every rising clock edge outside reset
`define URX_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must hold on the cycle after a trigger
`define URX_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

>>> rtl/core/urx_pkg.sv
// ----------------------------------------------------------------------------
// urx_pkg
// types and constants shared by the serial frame receiver files
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package urx_pkg;

   // frame phases
   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_DATA   = 2'd1,
      PH_PARITY = 2'd2,
      PH_STOP   = 2'd3
   } phase_type;

   // register indexes on the csr channel
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_BITS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARITY_MODE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_BITS   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MSB_FIRST   = 2'd3;

   // parity mode codes
   localparam logic [1:0] PAR_NONE = 2'd0;
   localparam logic [1:0] PAR_EVEN = 2'd1;
   localparam logic [1:0] PAR_ODD  = 2'd2;

   // register reset values
   localparam logic [3:0] DATA_BITS_RST   = 4'd8;
   localparam logic [1:0] PARITY_MODE_RST = PAR_NONE;
   localparam logic [2:0] STOP_BITS_RST   = 3'd1;
   localparam logic       MSB_FIRST_RST   = 1'b1;

   // frame format after clamping, as used by the frame logic
   typedef struct packed {
      logic [3:0] n_data;     // 1..8
      logic [2:0] n_stop;     // 1..4
      logic       parity_on;
      logic       parity_odd;
      logic       msb_first;
   } frame_cfg_type;

endpackage

`default_nettype wire

>>> rtl/core/urx_ifs.sv
// ----------------------------------------------------------------------------
// urx channel interfaces
// valid/ready channels for line bits, received bytes and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface urx_bit_if;
   logic valid;
   logic ready;
   logic line_bit;

   modport source (output valid, output line_bit, input ready);
   modport sink   (input valid, input line_bit, output ready);
endinterface

interface urx_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] received_byte;

   modport source (output valid, output received_byte, input ready);
   modport sink   (input valid, input received_byte, output ready);
endinterface

interface urx_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [3:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/core/urx_csr_regs.sv
// ----------------------------------------------------------------------------
// urx_csr_regs
// frame format registers with write decode and clamping of odd settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module urx_csr_regs
   import urx_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire logic [CSR_INDEX_W-1:0] wr_index,
   input  wire logic [CSR_DATA_W-1:0]  wr_data,
   output frame_cfg_type               cfg
);

   logic [3:0] data_bits_ff,   data_bits_in;
   logic [1:0] parity_mode_ff, parity_mode_in;
   logic [2:0] stop_bits_ff,   stop_bits_in;
   logic       msb_first_ff,   msb_first_in;

   // write decode
   always_comb begin
      data_bits_in   = data_bits_ff;
      parity_mode_in = parity_mode_ff;
      stop_bits_in   = stop_bits_ff;
      msb_first_in   = msb_first_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_DATA_BITS:   data_bits_in   = wr_data[3:0];
            CSR_PARITY_MODE: parity_mode_in = wr_data[1:0];
            CSR_STOP_BITS:   stop_bits_in   = wr_data[2:0];
            CSR_MSB_FIRST:   msb_first_in   = wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff   <= DATA_BITS_RST;
         parity_mode_ff <= PARITY_MODE_RST;
         stop_bits_ff   <= STOP_BITS_RST;
         msb_first_ff   <= MSB_FIRST_RST;
      end else begin
         data_bits_ff   <= data_bits_in;
         parity_mode_ff <= parity_mode_in;
         stop_bits_ff   <= stop_bits_in;
         msb_first_ff   <= msb_first_in;
      end
   end

   // zero counts act as one, large counts saturate, unused parity code is none
   always_comb begin
      if (data_bits_ff == 4'd0)      cfg.n_data = 4'd1;
      else if (data_bits_ff > 4'd8)  cfg.n_data = 4'd8;
      else                           cfg.n_data = data_bits_ff;

      if (stop_bits_ff == 3'd0)      cfg.n_stop = 3'd1;
      else if (stop_bits_ff > 3'd4)  cfg.n_stop = 3'd4;
      else                           cfg.n_stop = stop_bits_ff;

      cfg.parity_on  = (parity_mode_ff == PAR_EVEN) || (parity_mode_ff == PAR_ODD);
      cfg.parity_odd = (parity_mode_ff == PAR_ODD);
      cfg.msb_first  = msb_first_ff;
   end

endmodule

`default_nettype wire

>>> rtl/core/uart_frame_receiver.sv
// a good frame's byte is registered and shown in the cycle after its last stop bit is taken
// throughput: one line bit per cycle; ready drops only while a byte waits unread
// the frame state is updated in the cycle a bit is taken, the byte goes to an
// output register that frees itself in the same cycle it is read
// reset (synchronous, active high) returns to idle and restores register defaults
// ----------------------------------------------------------------------------
// uart_frame_receiver
// serial frame receiver taking one sampled line level per baud period
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uart_frame_receiver
   import urx_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   urx_bit_if.sink    req,
   urx_byte_if.source rsp,
   urx_csr_if.sink    csr
);

   frame_cfg_type cfg;

   phase_type  phase_ff,  phase_in;
   logic [3:0] count_ff,  count_in;
   logic [7:0] shift_ff,  shift_in;
   logic       par_ff,    par_in;
   logic       out_vld_ff, out_vld_in;
   logic [7:0] out_byte_ff, out_byte_in;

   logic       accept;
   logic       bit_val;
   logic [3:0] count_inc;
   logic       data_done;
   logic       stop_done;
   logic       emit;
   logic [3:0] lsb_pos;

   // configuration registers
   assign csr.ready = 1'b1;

   urx_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr.valid),
      .wr_index (csr.index),
      .wr_data  (csr.wdata),
      .cfg      (cfg)
   );

   // input handshake
   assign req.ready = !out_vld_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign bit_val   = req.line_bit;

   // phase counters
   assign count_inc = count_ff + 4'd1;
   assign data_done = (count_inc >= cfg.n_data);
   assign stop_done = (count_inc >= {1'b0, cfg.n_stop});
   assign lsb_pos   = cfg.n_data - 4'd1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (!bit_val) phase_in = PH_DATA;
            end
            PH_DATA: begin
               if (data_done) phase_in = cfg.parity_on ? PH_PARITY : PH_STOP;
            end
            PH_PARITY: begin
               phase_in = PH_STOP;
            end
            PH_STOP: begin
               if (!bit_val || stop_done) phase_in = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // frame datapath and result
   always_comb begin
      count_in = count_ff;
      shift_in = shift_ff;
      par_in   = par_ff;
      emit     = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (!bit_val) begin
                  count_in = 4'd0;
                  shift_in = 8'd0;
                  par_in   = cfg.parity_on && cfg.parity_odd;
               end
            end
            PH_DATA: begin
               if (cfg.msb_first) shift_in = {shift_ff[6:0], bit_val};
               else shift_in = (shift_ff >> 1) | (8'(bit_val) << lsb_pos[2:0]);
               par_in   = par_ff ^ bit_val;
               count_in = count_inc;
               if (data_done) begin
                  count_in = 4'd0;
                  // no parity: clear the accumulator so it reads as no error
                  if (!cfg.parity_on) par_in = 1'b0;
               end
            end
            PH_PARITY: begin
               par_in   = par_ff ^ bit_val;
               count_in = 4'd0;
            end
            PH_STOP: begin
               if (!bit_val) begin
                  count_in = 4'd0;
               end else begin
                  count_in = count_inc;
                  if (stop_done) begin
                     count_in = 4'd0;
                     emit     = !par_ff;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // output register
   always_comb begin
      out_vld_in  = out_vld_ff;
      out_byte_in = out_byte_ff;
      if (emit) begin
         out_vld_in  = 1'b1;
         out_byte_in = shift_ff;
      end else if (rsp.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         count_ff   <= 4'd0;
         shift_ff   <= 8'd0;
         par_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         shift_ff   <= shift_in;
         par_ff     <= par_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
   end

   assign rsp.valid         = out_vld_ff;
   assign rsp.received_byte = out_byte_ff;

endmodule

`default_nettype wire

>>> rtl/core/urx_checker.sv
// ----------------------------------------------------------------------------
// urx_checker
// port level checks of the serial frame receiver, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "uart_frame_receiver_assert.svh"

module urx_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_line_bit,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_received_byte
);

   // result transaction held until taken
   `URX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_received_byte), "rsp transaction dropped or changed while stalled")

   // a new result only follows an accepted high stop bit
   `URX_ASSERT(a_rsp_after_stop, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready && req_line_bit), "result without an accepted stop bit")

   // input is never stalled while the output register is empty
   `URX_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "input stalled with empty output")

   // freeing the output register reopens the input
   `URX_ASSERT(a_ready_on_take, clock, reset, rsp_valid && rsp_ready |-> req_ready, "input stalled while result is taken")

endmodule

bind uart_frame_receiver urx_checker u_urx_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .req_line_bit      (req.line_bit),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_received_byte (rsp.received_byte)
);

`default_nettype wire
